/* sv/fmss_pkg.sv */
// Shared types and constants for the flight mode setpoint sequencer.
// This file has no dependencies. All other files refer to it by scoped names.
package fmss_pkg;

    // Field widths
    localparam int YAW_W     = 9;
    localparam int ALT_W     = 7;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // One full turn of yaw in degrees. The held yaw setpoint stays in 0..FULL_TURN.
    localparam logic [YAW_W:0] FULL_TURN = 10'd360;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_YAW_STEP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_STEP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_ALT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_YAW_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_WINDOW  = 3'd5;

    // Values of the output mode field
    localparam logic [MODE_W-1:0] MODE_CODE_INIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_STARTUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_LANDED  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_FLYING  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_LANDING = 3'd4;

    // Flight mode, one-hot
    typedef enum logic [4:0] {
        MODE_INIT    = 5'b00001,
        MODE_STARTUP = 5'b00010,
        MODE_LANDED  = 5'b00100,
        MODE_FLYING  = 5'b01000,
        MODE_LANDING = 5'b10000
    } mode_t;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [7:0]       yaw_step;
        logic [5:0]       alt_step;
        logic [ALT_W-1:0] alt_limit;
        logic [ALT_W-1:0] land_alt;
        logic [7:0]       land_yaw_window;
        logic [7:0]       capture_window;
    } cfg_t;

    // One input word
    typedef struct packed {
        logic             switch_pushed;
        logic             left_pushed;
        logic             right_pushed;
        logic             up_pushed;
        logic             down_pushed;
        logic             at_reference;
        logic             control_tick;
        logic [YAW_W-1:0] yaw_actual;
        logic [ALT_W-1:0] alt_actual;
    } item_t;

    // One result word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [YAW_W-1:0]  yaw_setpoint;
        logic [ALT_W-1:0]  alt_setpoint;
        logic              clear_yaw_integral;
        logic              clear_alt_integral;
        logic              run_control;
    } result_t;

    // Held state of the sequencer
    typedef struct packed {
        mode_t            mode;
        logic [YAW_W-1:0] yaw_target;
        logic [ALT_W-1:0] alt_target;
    } state_t;

    // Numeric mode code for the output field.
    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_INIT:    c = MODE_CODE_INIT;
            MODE_STARTUP: c = MODE_CODE_STARTUP;
            MODE_LANDED:  c = MODE_CODE_LANDED;
            MODE_FLYING:  c = MODE_CODE_FLYING;
            MODE_LANDING: c = MODE_CODE_LANDING;
            default:      c = MODE_CODE_INIT;
        endcase
        return c;
    endfunction

endpackage

/* sv/fmss_if.sv */
// Valid/ready channel interfaces for input words and result words.
// Depends on fmss_pkg for field widths.
interface fmss_item_if;
    logic                       valid;
    logic                       ready;
    logic                       switch_pushed;
    logic                       left_pushed;
    logic                       right_pushed;
    logic                       up_pushed;
    logic                       down_pushed;
    logic                       at_reference;
    logic                       control_tick;
    logic [fmss_pkg::YAW_W-1:0] yaw_actual;
    logic [fmss_pkg::ALT_W-1:0] alt_actual;

    modport source (
        output valid, switch_pushed, left_pushed, right_pushed, up_pushed,
               down_pushed, at_reference, control_tick, yaw_actual, alt_actual,
        input  ready
    );
    modport sink (
        input  valid, switch_pushed, left_pushed, right_pushed, up_pushed,
               down_pushed, at_reference, control_tick, yaw_actual, alt_actual,
        output ready
    );
endinterface

interface fmss_result_if;
    logic                        valid;
    logic                        ready;
    logic [fmss_pkg::MODE_W-1:0] mode;
    logic [fmss_pkg::YAW_W-1:0]  yaw_setpoint;
    logic [fmss_pkg::ALT_W-1:0]  alt_setpoint;
    logic                        clear_yaw_integral;
    logic                        clear_alt_integral;
    logic                        run_control;

    modport source (
        output valid, mode, yaw_setpoint, alt_setpoint, clear_yaw_integral,
               clear_alt_integral, run_control,
        input  ready
    );
    modport sink (
        input  valid, mode, yaw_setpoint, alt_setpoint, clear_yaw_integral,
               clear_alt_integral, run_control,
        output ready
    );
endinterface

/* sv/fmss_cfg_regs.sv */
// Configuration register file of the setpoint sequencer.
// Depends on fmss_pkg for the register indexes and cfg_t.
module fmss_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fmss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmss_pkg::CFG_DAT_W-1:0]     cfg_data,
    output fmss_pkg::cfg_t                     cfg
);

    fmss_pkg::cfg_t cfg_reg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_step        <= 8'd15;
            cfg_reg.alt_step        <= 6'd10;
            cfg_reg.alt_limit       <= 7'd100;
            cfg_reg.land_alt        <= 7'd8;
            cfg_reg.land_yaw_window <= 8'd5;
            cfg_reg.capture_window  <= 8'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fmss_pkg::REG_YAW_STEP:        cfg_reg.yaw_step        <= cfg_data;
                fmss_pkg::REG_ALT_STEP:        cfg_reg.alt_step        <= cfg_data[5:0];
                fmss_pkg::REG_ALT_LIMIT:       cfg_reg.alt_limit       <= cfg_data[6:0];
                fmss_pkg::REG_LAND_ALT:        cfg_reg.land_alt        <= cfg_data[6:0];
                fmss_pkg::REG_LAND_YAW_WINDOW: cfg_reg.land_yaw_window <= cfg_data;
                fmss_pkg::REG_CAPTURE_WINDOW:  cfg_reg.capture_window  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/fmss_step_logic.sv */
// Combinational pass logic: mode switch transition, then the action of the new mode.
// Depends on fmss_pkg for the state, word and configuration types.
module fmss_step_logic (
    input  fmss_pkg::cfg_t    cfg,
    input  fmss_pkg::state_t  state_cur,
    input  fmss_pkg::item_t   word_in,
    output fmss_pkg::state_t  state_nxt,
    output fmss_pkg::result_t res
);

    // Yaw step up; a sum above one turn wraps into 1..FULL_TURN.
    function automatic logic [fmss_pkg::YAW_W-1:0] yaw_up(
        input logic [fmss_pkg::YAW_W-1:0] t,
        input logic [7:0]                 step
    );
        logic [fmss_pkg::YAW_W:0] v;
        v = {1'b0, t} + {2'b00, step};
        if (v > fmss_pkg::FULL_TURN)
        begin
            v = v - fmss_pkg::FULL_TURN;
        end
        return v[fmss_pkg::YAW_W-1:0];
    endfunction

    // Yaw step down; a difference below zero wraps into 0..FULL_TURN-1.
    function automatic logic [fmss_pkg::YAW_W-1:0] yaw_down(
        input logic [fmss_pkg::YAW_W-1:0] t,
        input logic [7:0]                 step
    );
        logic [fmss_pkg::YAW_W:0] v;
        v = {1'b0, t} - {2'b00, step};
        if ({1'b0, t} < {2'b00, step})
        begin
            v = v + fmss_pkg::FULL_TURN;
        end
        return v[fmss_pkg::YAW_W-1:0];
    endfunction

    // Altitude step down, saturating at zero.
    function automatic logic [fmss_pkg::ALT_W-1:0] alt_down(
        input logic [fmss_pkg::ALT_W-1:0] a,
        input logic [5:0]                 step
    );
        logic [fmss_pkg::ALT_W-1:0] r;
        if (a >= {1'b0, step})
        begin
            r = a - {1'b0, step};
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    fmss_pkg::mode_t            m;
    logic [fmss_pkg::YAW_W-1:0] y;
    logic [fmss_pkg::ALT_W-1:0] a;
    logic [fmss_pkg::ALT_W:0]   a_sum;
    logic                       clr_yaw;
    logic                       clr_alt;
    logic                       run;
    logic                       near_ref;
    logic                       captured;

    // Heading near the reference: within the window on either side of zero.
    assign near_ref = ({1'b0, word_in.yaw_actual} < {2'b00, cfg.land_yaw_window})
                   || ({1'b0, word_in.yaw_actual}
                       > (fmss_pkg::FULL_TURN - {2'b00, cfg.land_yaw_window}));

    // Measured yaw strictly within the capture window of the current target.
    assign captured = ({1'b0, word_in.yaw_actual}
                       < ({1'b0, state_cur.yaw_target} + {2'b00, cfg.capture_window}))
                   && (({1'b0, word_in.yaw_actual} + {2'b00, cfg.capture_window})
                       > {1'b0, state_cur.yaw_target});

    always_comb
    begin
        m       = state_cur.mode;
        y       = state_cur.yaw_target;
        a       = state_cur.alt_target;
        a_sum   = '0;
        clr_yaw = 1'b0;
        clr_alt = 1'b0;
        run     = 1'b0;

        // Switch transition
        if (word_in.switch_pushed)
        begin
            case (m)
                fmss_pkg::MODE_INIT:
                begin
                    m = fmss_pkg::MODE_STARTUP;
                end
                fmss_pkg::MODE_LANDED:
                begin
                    clr_yaw = 1'b1;
                    clr_alt = 1'b1;
                    m       = fmss_pkg::MODE_FLYING;
                end
                fmss_pkg::MODE_FLYING:
                begin
                    a = alt_down(word_in.alt_actual, cfg.alt_step);
                    y = '0;
                    m = fmss_pkg::MODE_LANDING;
                end
                default:
                begin
                end
            endcase
        end

        // Action of the mode now in force
        case (m)
            fmss_pkg::MODE_STARTUP:
            begin
                if (word_in.at_reference)
                begin
                    a       = '0;
                    y       = '0;
                    clr_yaw = 1'b1;
                    m       = fmss_pkg::MODE_FLYING;
                end
                else if (word_in.control_tick)
                begin
                    if (captured)
                    begin
                        y       = yaw_up(y, cfg.yaw_step);
                        clr_yaw = 1'b1;
                    end
                    run = 1'b1;
                end
            end
            fmss_pkg::MODE_FLYING:
            begin
                if (word_in.left_pushed)
                begin
                    y = yaw_down(y, cfg.yaw_step);
                end
                if (word_in.right_pushed)
                begin
                    y = yaw_up(y, cfg.yaw_step);
                end
                if (word_in.up_pushed && (a < cfg.alt_limit))
                begin
                    a_sum = {1'b0, a} + {2'b00, cfg.alt_step};
                    if (a_sum > {1'b0, cfg.alt_limit})
                    begin
                        a = cfg.alt_limit;
                    end
                    else
                    begin
                        a = a_sum[fmss_pkg::ALT_W-1:0];
                    end
                end
                if (word_in.down_pushed)
                begin
                    a = alt_down(a, cfg.alt_step);
                end
                run = word_in.control_tick;
            end
            fmss_pkg::MODE_LANDING:
            begin
                if ((word_in.alt_actual < cfg.land_alt) && near_ref)
                begin
                    clr_alt = 1'b1;
                    clr_yaw = 1'b1;
                    a       = '0;
                    m       = fmss_pkg::MODE_LANDED;
                end
                else if (word_in.control_tick)
                begin
                    if (near_ref)
                    begin
                        a = '0;
                    end
                    run = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign state_nxt.mode       = m;
    assign state_nxt.yaw_target = y;
    assign state_nxt.alt_target = a;

    assign res.mode               = fmss_pkg::mode_code(m);
    assign res.yaw_setpoint       = y;
    assign res.alt_setpoint       = a;
    assign res.clear_yaw_integral = clr_yaw;
    assign res.clear_alt_integral = clr_alt;
    assign res.run_control        = run;

endmodule

/* sv/flight_mode_setpoint_sequencer_unit.sv */
// An accepted word is held in the input register; its result is then registered in the result register.
// One word per cycle while result.ready is high; input and result registers hold one word each.
// The mode and setpoint registers update when a word moves from the input to the result register.
// Reset (rst_n low, asynchronous) gives init mode, zero setpoints, default configuration
// and empty pipeline registers.
// Top level; depends on fmss_pkg, fmss_if, fmss_cfg_regs and fmss_step_logic.
module flight_mode_setpoint_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fmss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fmss_pkg::CFG_DAT_W-1:0] cfg_data,
    fmss_item_if.sink                      item,
    fmss_result_if.source                  result
);

    fmss_pkg::cfg_t    cfg;
    fmss_pkg::state_t  state_reg;
    fmss_pkg::state_t  state_next;
    fmss_pkg::item_t   in_word;
    fmss_pkg::item_t   in_word_reg;
    fmss_pkg::result_t res_next;
    fmss_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              in_take;
    logic              advance;

    fmss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fmss_step_logic u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .word_in   (in_word_reg),
        .state_nxt (state_next),
        .res       (res_next)
    );

    // Gather the input word from the channel.
    assign in_word.switch_pushed = item.switch_pushed;
    assign in_word.left_pushed   = item.left_pushed;
    assign in_word.right_pushed  = item.right_pushed;
    assign in_word.up_pushed     = item.up_pushed;
    assign in_word.down_pushed   = item.down_pushed;
    assign in_word.at_reference  = item.at_reference;
    assign in_word.control_tick  = item.control_tick;
    assign in_word.yaw_actual    = item.yaw_actual;
    assign in_word.alt_actual    = item.alt_actual;

    // Handshake: the held word moves on when the result register is free or being emptied.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_take    = item.valid && item.ready;

    // Pipeline valid flags and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.mode       <= fmss_pkg::MODE_INIT;
            state_reg.yaw_target <= '0;
            state_reg.alt_target <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result channel.
    assign result.valid              = out_valid_reg;
    assign result.mode               = res_reg.mode;
    assign result.yaw_setpoint       = res_reg.yaw_setpoint;
    assign result.alt_setpoint       = res_reg.alt_setpoint;
    assign result.clear_yaw_integral = res_reg.clear_yaw_integral;
    assign result.clear_alt_integral = res_reg.clear_alt_integral;
    assign result.run_control        = res_reg.run_control;

    // The held yaw setpoint never leaves 0..FULL_TURN.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.yaw_target} <= fmss_pkg::FULL_TURN)
        else $error("yaw setpoint out of range");

    // State only changes when a word moves into the result register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a word");

    // The altitude integral is cleared only on entry to landed or flying.
    a_clr_alt_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.clear_alt_integral |->
            (res_reg.mode == fmss_pkg::MODE_CODE_LANDED)
            || (res_reg.mode == fmss_pkg::MODE_CODE_FLYING))
        else $error("altitude integral cleared in wrong mode");

    // No control update is requested while landed or in init.
    a_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.run_control |->
            (res_reg.mode != fmss_pkg::MODE_CODE_LANDED)
            && (res_reg.mode != fmss_pkg::MODE_CODE_INIT))
        else $error("control update while landed or in init");

endmodule
